/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* rtl/core/ptfl_pkg.sv */
// Types and constants of the page table with FIFO or LRU replacement.
`default_nettype none

package ptfl_pkg;

    localparam int PID_W      = 16;
    localparam int ADDR_W     = 32;
    localparam int STAMP_W    = 32;
    localparam int CNT_W      = 32;
    localparam int SLOT_W     = 6;
    localparam int ENTRIES_W  = 7;
    localparam int PSZ_W      = 17;
    localparam int DIV_W      = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY    = 2'd2;

    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    localparam logic [ENTRIES_W-1:0] RST_ENTRIES   = 7'd64;
    localparam logic [PSZ_W-1:0]     RST_PAGE_SIZE = 17'd4096;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SEARCH,
        S_VICT,
        S_MOD,
        S_WRITE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic start;
        logic victim;
        logic wr_en;
    } t_scan_ctl;

    typedef struct packed {
        logic done;
        logic found;
    } t_scan_sts;

endpackage

`default_nettype wire

/* rtl/core/ptfl_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none

module ptfl_div
    import ptfl_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [ADDR_W-1:0] i_dividend,
    input  wire logic [DIV_W-1:0]  i_divisor,
    output logic                   o_done,
    output logic [ADDR_W-1:0]      o_quot,
    output logic [DIV_W-1:0]       o_rem
);

    localparam int STEP_W = $clog2(ADDR_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ADDR_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [ADDR_W-1:0] r_quot;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_den;

    logic [DIV_W:0] shifted;
    logic [DIV_W:0] diff;
    logic           ge;

    always_comb begin
        shifted = {r_rem, r_quot[ADDR_W-1]};
        diff    = shifted - {1'b0, r_den};
        ge      = shifted >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == LAST_STEP);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + STEP_W'(1);
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_den  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[ADDR_W-2:0], ge};
            r_rem  <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

/* rtl/core/ptfl_scan.sv */
// Entry memory with the sequential match search and oldest-stamp victim scan.
`default_nettype none

module ptfl_scan
    import ptfl_pkg::*;
#(
    parameter int MAX_ENTRIES = 64,
    parameter int PW          = 16,
    parameter int IW          = 6,
    parameter int CW          = 7
)
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_scan_ctl          i_ctl,
    input  wire logic [CW-1:0]      i_limit,
    input  wire logic [PW-1:0]      i_key_pid,
    input  wire logic [ADDR_W-1:0]  i_key_page,
    input  wire logic [IW-1:0]      i_wr_slot,
    input  wire logic [STAMP_W-1:0] i_wr_stamp,
    output t_scan_sts               o_sts,
    output logic [IW-1:0]           o_slot
);

    localparam int WW = PW + ADDR_W + STAMP_W;

    logic [WW-1:0] r_mem [MAX_ENTRIES];
    logic [WW-1:0] r_rd_data;

    logic               r_busy;
    logic               r_victim;
    logic               r_first;
    logic               r_cmp_vld;
    logic               r_done;
    logic               r_found;
    logic [CW-1:0]      r_addr;
    logic [CW-1:0]      r_limit;
    logic [IW-1:0]      r_cmp_idx;
    logic [IW-1:0]      r_best_idx;
    logic [IW-1:0]      r_slot;
    logic [STAMP_W-1:0] r_best;

    logic [PW-1:0]      rd_pid;
    logic [ADDR_W-1:0]  rd_page;
    logic [STAMP_W-1:0] rd_stamp;
    logic               match;
    logic               issue;
    logic               finish;
    logic               less;

    always_comb begin
        rd_pid   = r_rd_data[WW-1 -: PW];
        rd_page  = r_rd_data[STAMP_W +: ADDR_W];
        rd_stamp = r_rd_data[STAMP_W-1:0];
        match    = r_cmp_vld && !r_victim && (rd_pid == i_key_pid) && (rd_page == i_key_page);
        issue    = r_busy && (r_addr < r_limit) && !match;
        finish   = r_busy && !(r_addr < r_limit) && !r_cmp_vld;
        less     = r_first || (rd_stamp < r_best);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_slot] <= {i_key_pid, i_key_page, i_wr_stamp};
        end
        if (issue) begin
            r_rd_data <= r_mem[r_addr[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_done    <= 1'b0;
            r_first   <= 1'b1;
        end else begin
            r_done <= !i_ctl.start && (match || finish);
            if (i_ctl.start) begin
                r_busy    <= 1'b1;
                r_cmp_vld <= 1'b0;
                r_first   <= 1'b1;
            end else begin
                r_cmp_vld <= issue;
                if (r_cmp_vld && r_victim && less) begin
                    r_first <= 1'b0;
                end
                if (match || finish) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_addr   <= '0;
            r_limit  <= i_limit;
            r_victim <= i_ctl.victim;
        end else begin
            if (issue) begin
                r_addr <= r_addr + CW'(1);
            end
            r_cmp_idx <= r_addr[IW-1:0];
            if (r_cmp_vld && r_victim && less) begin
                r_best     <= rd_stamp;
                r_best_idx <= r_cmp_idx;
            end
            if (match) begin
                r_found <= 1'b1;
                r_slot  <= r_cmp_idx;
            end else if (finish) begin
                r_found <= 1'b0;
                r_slot  <= r_best_idx;
            end
        end
    end

    assign o_sts  = '{done: r_done, found: r_found};
    assign o_slot = r_slot;

endmodule

`default_nettype wire

/* rtl/core/page_table_fifo_lru_replacement_top.sv */
// Top level of the fully associative page table with FIFO or LRU replacement.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------------
//  access   | i_in_valid / o_in_ready   | i_process_id, i_address
//  result   | o_out_valid / i_out_ready | o_hit, o_slot, o_page_number, o_miss_total
//  config   | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  One request at a time. Page division runs in the shared divider, the match search
//  steps through the filled slots over the entry memory's single read port.
//  A miss on a full table adds a stamp scan (LRU) or a modulo in the same divider
//  (FIFO), then the write-back and the result load. Reset is synchronous; the entry
//  memory needs no clearing pass, only filled slots are read. A stalled result holds
//  the block in its final state.
`default_nettype none

module page_table_fifo_lru_replacement_top
    import ptfl_pkg::*;
#(
    parameter int MAX_ENTRIES  = 64,
    parameter int PROCESS_BITS = 16
)
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [PID_W-1:0]      i_process_id,
    input  wire logic [ADDR_W-1:0]     i_address,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_hit,
    output logic [SLOT_W-1:0]          o_slot,
    output logic [ADDR_W-1:0]          o_page_number,
    output logic [CNT_W-1:0]           o_miss_total,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

`include "assert_macros.svh"

    localparam int PW = (PROCESS_BITS < PID_W) ? PROCESS_BITS : PID_W;
    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int EW = (CW > ENTRIES_W) ? CW : ENTRIES_W;

    t_state r_state;
    t_state n_state;

    logic [ENTRIES_W-1:0] r_entries;
    logic [PSZ_W-1:0]     r_page_size;
    logic                 r_policy;

    logic [CW-1:0]      r_filled;
    logic [STAMP_W-1:0] r_time;
    logic [CNT_W-1:0]   r_miss;

    logic [PW-1:0]      r_pid;
    logic [ADDR_W-1:0]  r_page;
    logic [IW-1:0]      r_slot;
    logic               r_hit;

    logic               r_out_valid;
    logic               r_o_hit;
    logic [SLOT_W-1:0]  r_o_slot;
    logic [ADDR_W-1:0]  r_o_page;
    logic [CNT_W-1:0]   r_o_miss;

    logic [EW-1:0]      eu_ext;
    logic [EW-1:0]      max_ext;
    logic [CW-1:0]      n_eff;
    logic [PSZ_W-1:0]   psz;
    logic               has_room;
    logic [31:0]        slot_ext;

    logic               in_ready;
    logic               div_start;
    logic               div_mod;
    logic               scan_start;
    logic               scan_victim;
    logic               hit_take;
    logic               miss_take;
    logic               fill_take;
    logic               vict_take;
    logic               mod_take;
    logic               wr_en;
    logic               out_load;

    logic [ADDR_W-1:0]  div_dividend;
    logic [DIV_W-1:0]   div_divisor;
    logic               div_done;
    logic [ADDR_W-1:0]  div_quot;
    logic [DIV_W-1:0]   div_rem;

    t_scan_ctl          scan_ctl;
    t_scan_sts          scan_sts;
    logic [IW-1:0]      scan_slot;
    logic [CW-1:0]      scan_limit;

    always_comb begin
        eu_ext   = EW'(r_entries);
        max_ext  = EW'(MAX_ENTRIES);
        if (eu_ext == '0) begin
            n_eff = CW'(1);
        end else if (eu_ext > max_ext) begin
            n_eff = CW'(max_ext);
        end else begin
            n_eff = CW'(eu_ext);
        end
        psz      = (r_page_size == '0) ? PSZ_W'(1) : r_page_size;
        has_room = r_filled < n_eff;
        slot_ext = 32'(r_slot);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries   <= RST_ENTRIES;
            r_page_size <= RST_PAGE_SIZE;
            r_policy    <= POLICY_FIFO;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ENTRIES:   r_entries   <= i_cfg_data[ENTRIES_W-1:0];
                CFG_PAGE_SIZE: r_page_size <= i_cfg_data[PSZ_W-1:0];
                CFG_POLICY:    r_policy    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (scan_sts.done) begin
                    if (scan_sts.found || has_room) begin
                        n_state = S_WRITE;
                    end else if (r_policy == POLICY_LRU) begin
                        n_state = S_VICT;
                    end else begin
                        n_state = S_MOD;
                    end
                end
            end
            S_VICT: begin
                if (scan_sts.done) begin
                    n_state = S_WRITE;
                end
            end
            S_MOD: begin
                if (div_done) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: n_state = S_DONE;
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        in_ready    = 1'b0;
        div_start   = 1'b0;
        div_mod     = 1'b0;
        scan_start  = 1'b0;
        scan_victim = 1'b0;
        hit_take    = 1'b0;
        miss_take   = 1'b0;
        fill_take   = 1'b0;
        vict_take   = 1'b0;
        mod_take    = 1'b0;
        wr_en       = 1'b0;
        out_load    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                in_ready  = 1'b1;
                div_start = i_in_valid;
            end
            S_DIV: begin
                scan_start = div_done;
            end
            S_SEARCH: begin
                if (scan_sts.done) begin
                    hit_take  = scan_sts.found;
                    miss_take = !scan_sts.found;
                    if (!scan_sts.found) begin
                        if (has_room) begin
                            fill_take = 1'b1;
                        end else if (r_policy == POLICY_LRU) begin
                            scan_start  = 1'b1;
                            scan_victim = 1'b1;
                        end else begin
                            div_start = 1'b1;
                            div_mod   = 1'b1;
                        end
                    end
                end
            end
            S_VICT:  vict_take = scan_sts.done;
            S_MOD:   mod_take  = div_done;
            S_WRITE: wr_en     = 1'b1;
            S_DONE:  out_load  = !r_out_valid || i_out_ready;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_filled    <= '0;
            r_time      <= '0;
            r_miss      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (miss_take && (r_miss != '1)) begin
                r_miss <= r_miss + CNT_W'(1);
            end
            if (fill_take) begin
                r_filled <= r_filled + CW'(1);
            end
            if (wr_en && (!r_hit || (r_policy == POLICY_LRU))) begin
                r_time <= r_time + STAMP_W'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_start && !div_mod) begin
            r_pid <= i_process_id[PW-1:0];
        end
        if ((r_state == S_DIV) && div_done) begin
            r_page <= div_quot;
        end
        if (hit_take) begin
            r_hit  <= 1'b1;
            r_slot <= scan_slot;
        end
        if (miss_take) begin
            r_hit <= 1'b0;
        end
        if (fill_take) begin
            r_slot <= r_filled[IW-1:0];
        end
        if (vict_take) begin
            r_slot <= scan_slot;
        end
        if (mod_take) begin
            r_slot <= div_rem[IW-1:0];
        end
        if (out_load) begin
            r_o_hit  <= r_hit;
            r_o_slot <= slot_ext[SLOT_W-1:0];
            r_o_page <= r_page;
            r_o_miss <= r_miss;
        end
    end

    always_comb begin
        div_dividend = div_mod ? r_miss : i_address;
        div_divisor  = div_mod ? DIV_W'(n_eff) : DIV_W'(psz);
        scan_limit   = scan_victim ? n_eff : r_filled;
        scan_ctl     = '{start: scan_start, victim: scan_victim, wr_en: wr_en};
    end

    ptfl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    ptfl_scan #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .PW          (PW),
        .IW          (IW),
        .CW          (CW)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (scan_ctl),
        .i_limit    (scan_limit),
        .i_key_pid  (r_pid),
        .i_key_page (r_page),
        .i_wr_slot  (r_slot),
        .i_wr_stamp (r_time),
        .o_sts      (scan_sts),
        .o_slot     (scan_slot)
    );

    assign o_in_ready    = in_ready;
    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_o_hit;
    assign o_slot        = r_o_slot;
    assign o_page_number = r_o_page;
    assign o_miss_total  = r_o_miss;

    `ASSERT_IMPLIES(a_fill_bound, i_clk, i_rst_n, 1'b1, r_filled <= CW'(MAX_ENTRIES))
    `ASSERT_NEXT(a_one_request, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `ASSERT_NEXT(a_fill_on_miss, i_clk, i_rst_n, r_state != S_SEARCH, $stable(r_filled))
    `ASSERT_IMPLIES(a_miss_counted, i_clk, i_rst_n, o_out_valid && !o_hit, o_miss_total != '0)

endmodule

`default_nettype wire

/* test/tb_page_table_fifo_lru_replacement_top.sv */
// Self-checking testbench for the page table with FIFO or LRU replacement.
module tb_page_table_fifo_lru_replacement_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ptfl_pkg::*;

    localparam int MAX_SLOTS   = 64;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int SEGMENTS    = 13;
    localparam int SEG_ITEMS   = 100;
    localparam int REPORT_MAX  = 10;
    localparam int TAIL_CYCLES = 200;

    typedef enum logic {ROW_ACCESS, ROW_WRITE} t_row_kind;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] page;
        logic [CNT_W-1:0]  misses;
    } t_lookup;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        logic [PID_W-1:0]      pid;
        logic [ADDR_W-1:0]     addr;
        bit                    known;
        t_lookup               want;
    } t_plan_row;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_in_valid   = 1'b0;
    logic [PID_W-1:0]      i_process_id = '0;
    logic [ADDR_W-1:0]     i_address    = '0;
    logic                  i_out_ready  = 1'b0;
    logic                  i_cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic                  o_hit;
    logic [SLOT_W-1:0]     o_slot;
    logic [ADDR_W-1:0]     o_page_number;
    logic [CNT_W-1:0]      o_miss_total;
    logic                  o_cfg_ready;

    // travels with the request so the checker can take a typed expectation
    bit      req_known = 1'b0;
    t_lookup req_want  = '0;

    // shadow registers and table
    logic [ENTRIES_W-1:0] tbl_entries = RST_ENTRIES;
    logic [PSZ_W-1:0]     pg_size     = RST_PAGE_SIZE;
    logic                 use_policy  = POLICY_FIFO;
    int                   filled      = 0;
    logic [PID_W-1:0]     ent_pid   [MAX_SLOTS];
    logic [ADDR_W-1:0]    ent_page  [MAX_SLOTS];
    logic [STAMP_W-1:0]   ent_stamp [MAX_SLOTS];
    logic [STAMP_W-1:0]   time_now    = '0;
    logic [CNT_W-1:0]     miss_count  = '0;

    t_lookup   pending_lookups[$];
    t_plan_row plan_q[$];
    int        sent_total    = 0;
    int        checked_total = 0;
    int        fault_count   = 0;
    int        tx_idle_pct   = 10;
    int        rx_idle_pct   = 55;
    int        hold_asked    = 0;

    page_table_fifo_lru_replacement_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_process_id  (i_process_id),
        .i_address     (i_address),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_hit         (o_hit),
        .o_slot        (o_slot),
        .o_page_number (o_page_number),
        .o_miss_total  (o_miss_total),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_lookup translate_access(input logic [PID_W-1:0] pid,
                                                 input logic [ADDR_W-1:0] addr);
        t_lookup            r;
        logic [ADDR_W-1:0]  divisor;
        logic [ADDR_W-1:0]  page;
        logic [STAMP_W-1:0] now;
        logic [STAMP_W-1:0] low;
        logic [CNT_W-1:0]   prior;
        int                 n;
        int                 i;
        int                 slot_i;
        bit                 found;
        divisor = (pg_size == '0) ? 32'd1 : ADDR_W'(pg_size);
        page    = addr / divisor;
        n       = (tbl_entries == '0) ? 1 : (tbl_entries > MAX_SLOTS) ? MAX_SLOTS : tbl_entries;
        now     = time_now;
        found   = 1'b0;
        slot_i  = 0;
        for (i = 0; i < filled && i < MAX_SLOTS; i++) begin
            if (!found && ent_pid[i] == pid && ent_page[i] == page) begin
                found        = 1'b1;
                slot_i       = i;
                ent_stamp[i] = now;
            end
        end
        if (!found) begin
            prior = miss_count;
            if (miss_count != '1) miss_count = miss_count + 1'b1;
            if (filled < n) begin
                slot_i = filled;
                filled++;
            end else if (use_policy == POLICY_LRU) begin
                low    = ent_stamp[0];
                slot_i = 0;
                for (i = 1; i < n; i++) begin
                    if (ent_stamp[i] < low) begin
                        low    = ent_stamp[i];
                        slot_i = i;
                    end
                end
            end else begin
                slot_i = int'(prior % CNT_W'(n));
            end
            ent_pid[slot_i]   = pid;
            ent_page[slot_i]  = page;
            ent_stamp[slot_i] = now;
        end
        if (!found || use_policy == POLICY_LRU) time_now = now + 1'b1;
        r.hit    = found;
        r.slot   = slot_i[SLOT_W-1:0];
        r.page   = page;
        r.misses = miss_count;
        return r;
    endfunction

    function automatic void plan_write(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
        t_plan_row row;
        row.kind     = ROW_WRITE;
        row.reg_idx  = idx;
        row.reg_data = data;
        row.pid      = '0;
        row.addr     = '0;
        row.known    = 1'b0;
        row.want     = '0;
        plan_q.insert(plan_q.size(), row);
    endfunction

    function automatic void plan_access(input logic [PID_W-1:0] pid,
                                        input logic [ADDR_W-1:0] addr);
        t_plan_row row;
        row.kind     = ROW_ACCESS;
        row.reg_idx  = '0;
        row.reg_data = '0;
        row.pid      = pid;
        row.addr     = addr;
        row.known    = 1'b0;
        row.want     = '0;
        plan_q.insert(plan_q.size(), row);
    endfunction

    function automatic void plan_known(input logic [PID_W-1:0] pid,
                                       input logic [ADDR_W-1:0] addr,
                                       input logic hit, input int slot,
                                       input logic [ADDR_W-1:0] page,
                                       input logic [CNT_W-1:0] misses);
        t_plan_row row;
        row.kind        = ROW_ACCESS;
        row.reg_idx     = '0;
        row.reg_data    = '0;
        row.pid         = pid;
        row.addr        = addr;
        row.known       = 1'b1;
        row.want.hit    = hit;
        row.want.slot   = slot[SLOT_W-1:0];
        row.want.page   = page;
        row.want.misses = misses;
        plan_q.insert(plan_q.size(), row);
    endfunction

    task automatic send_access(input logic [PID_W-1:0] pid, input logic [ADDR_W-1:0] addr,
                               input bit known, input t_lookup want);
        i_in_valid   <= 1'b1;
        i_process_id <= pid;
        i_address    <= addr;
        req_known    <= known;
        req_want     <= want;
        do @(posedge i_clk); while (!o_in_ready);
        sent_total++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (checked_total != sent_total) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : check_results
        t_lookup got;
        t_lookup want;
        bit      moved;
        int      quiet;
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
                case (i_cfg_index)
                    CFG_ENTRIES:   tbl_entries = i_cfg_data[ENTRIES_W-1:0];
                    CFG_PAGE_SIZE: pg_size     = i_cfg_data[PSZ_W-1:0];
                    CFG_POLICY:    use_policy  = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (o_out_valid && i_out_ready) begin
                moved       = 1'b1;
                got.hit     = o_hit;
                got.slot    = o_slot;
                got.page    = o_page_number;
                got.misses  = o_miss_total;
                checked_total++;
                if (pending_lookups.size() == 0) begin
                    if (fault_count < REPORT_MAX)
                        $display({"result %0d with no request outstanding: ",
                                  "hit=%0d slot=%0d page=%h misses=%0d"},
                                 checked_total, got.hit, got.slot, got.page, got.misses);
                    fault_count++;
                end else begin
                    want = pending_lookups.pop_front();
                    if (got.hit !== want.hit || got.slot !== want.slot ||
                        got.page !== want.page || got.misses !== want.misses) begin
                        if (fault_count < REPORT_MAX)
                            $display({"result %0d: expected hit=%0d slot=%0d page=%h ",
                                      "misses=%0d, got hit=%0d slot=%0d page=%h misses=%0d"},
                                     checked_total, want.hit, want.slot, want.page,
                                     want.misses, got.hit, got.slot, got.page, got.misses);
                        fault_count++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                moved = 1'b1;
                want  = translate_access(i_process_id, i_address);
                if (req_known) want = req_want;
                pending_lookups.insert(pending_lookups.size(), want);
            end
            quiet = moved ? 0 : quiet + 1;
            if (quiet >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin : result_sink
        int hold_left;
        int hold_taken;
        hold_left  = 0;
        hold_taken = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0 && hold_taken != hold_asked) begin
                hold_taken++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin : stimulus
        int                    r;
        int                    seg;
        int                    k;
        int                    eff_n;
        int                    ws_pages;
        logic [ENTRIES_W-1:0]  set_entries;
        logic [PSZ_W-1:0]      set_psz;
        logic                  set_pol;
        logic [ADDR_W-1:0]     eff_psz;
        logic [ADDR_W-1:0]     top_page;
        logic [ADDR_W-1:0]     base_page;
        logic [PID_W-1:0]      pid_a;
        logic [PID_W-1:0]      pid_b;
        logic [PID_W-1:0]      pid;
        logic [ADDR_W-1:0]     addr;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        plan_known(16'h0000, 32'h0000_0000, 1'b0, 0, 32'h0000_0000, 1);
        plan_known(16'h0000, 32'h0000_0FFF, 1'b1, 0, 32'h0000_0000, 1);
        plan_known(16'hFFFF, 32'hFFFF_FFFF, 1'b0, 1, 32'h000F_FFFF, 2);
        plan_known(16'h0001, 32'h0000_0000, 1'b0, 2, 32'h0000_0000, 3);
        plan_known(16'hFFFF, 32'hFFFF_F000, 1'b1, 1, 32'h000F_FFFF, 3);
        // zero page size acts as one byte per page
        plan_write(CFG_PAGE_SIZE, 17'd0);
        plan_known(16'h0002, 32'h1234_5678, 1'b0, 3, 32'h1234_5678, 4);
        plan_known(16'h0000, 32'h0000_0000, 1'b1, 0, 32'h0000_0000, 4);
        plan_write(CFG_PAGE_SIZE, 17'd65536);
        plan_known(16'h0002, 32'hFFFF_FFFF, 1'b0, 4, 32'h0000_FFFF, 5);
        plan_write(CFG_PAGE_SIZE, 17'h1FFFF);
        plan_access(16'h0002, 32'hFFFF_FFFF);
        // zero table size, below the filled count
        plan_write(CFG_ENTRIES, 17'd0);
        plan_access(16'h0003, 32'h0000_0000);
        plan_access(16'h0000, 32'h0000_0000);
        plan_write(CFG_ENTRIES, 17'd127);
        plan_write(CFG_POLICY, CFG_DATA_W'(POLICY_LRU));
        plan_access(16'h0001, 32'h0000_0005);
        plan_access(16'h0005, 32'h0000_0000);
        plan_write(CFG_ENTRIES, 17'd2);
        plan_access(16'h0006, 32'h0000_0000);
        plan_access(16'h0007, 32'h0000_0000);
        plan_access(16'h0006, 32'h0000_0000);
        plan_access(16'h0008, 32'h0000_0000);
        plan_write(CFG_POLICY, CFG_DATA_W'(POLICY_FIFO));
        plan_access(16'h0009, 32'h0000_0000);
        plan_access(16'h0007, 32'h0000_0000);
        plan_write(CFG_ENTRIES, 17'd64);

        for (r = 0; r < plan_q.size(); r++) begin
            if (plan_q[r].kind == ROW_WRITE) begin
                drain();
                write_reg(plan_q[r].reg_idx, plan_q[r].reg_data);
                if (r + 1 == plan_q.size() || plan_q[r + 1].kind != ROW_WRITE)
                    i_cfg_valid <= 1'b0;
            end else begin
                send_access(plan_q[r].pid, plan_q[r].addr, plan_q[r].known, plan_q[r].want);
            end
        end

        for (seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == 4) begin
                tx_idle_pct = 55;
                rx_idle_pct = 10;
            end
            if (seg == 8) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (seg)
                0:  begin set_entries = 7'd64;  set_psz = 17'd4096;  set_pol = POLICY_FIFO; end
                1:  begin set_entries = 7'd1;   set_psz = 17'd1;     set_pol = POLICY_LRU;  end
                2:  begin set_entries = 7'd64;  set_psz = 17'd65536; set_pol = POLICY_LRU;  end
                3:  begin set_entries = 7'd8;   set_psz = 17'd0;     set_pol = POLICY_FIFO; end
                4:  begin set_entries = 7'd127; set_psz = 17'h1FFFF; set_pol = POLICY_LRU;  end
                5:  begin set_entries = 7'd0;   set_psz = 17'd512;   set_pol = POLICY_FIFO; end
                6:  begin set_entries = 7'd16;  set_psz = 17'd4096;  set_pol = POLICY_LRU;  end
                7:  begin set_entries = 7'd3;   set_psz = 17'd100;   set_pol = POLICY_FIFO; end
                8:  begin set_entries = 7'd40;  set_psz = 17'd1;     set_pol = POLICY_LRU;  end
                12: begin set_entries = 7'd64;  set_psz = 17'd4096;  set_pol = POLICY_FIFO; end
                default: begin
                    set_entries = ENTRIES_W'($urandom_range(127));
                    set_psz     = PSZ_W'($urandom_range(131071));
                    set_pol     = 1'($urandom_range(1));
                end
            endcase
            drain();
            write_reg(CFG_ENTRIES, CFG_DATA_W'(set_entries));
            write_reg(CFG_PAGE_SIZE, CFG_DATA_W'(set_psz));
            write_reg(CFG_POLICY, CFG_DATA_W'(set_pol));
            i_cfg_valid <= 1'b0;

            eff_n     = (set_entries == '0) ? 1 :
                        (set_entries > MAX_SLOTS) ? MAX_SLOTS : set_entries;
            eff_psz   = (set_psz == '0) ? 32'd1 : ADDR_W'(set_psz);
            ws_pages  = eff_n * 3 / 4 + 1;
            pid_a     = PID_W'($urandom);
            pid_b     = PID_W'($urandom);
            top_page  = 32'hFFFF_FFFF / eff_psz;
            base_page = (seg % 3 == 0) ? '0 : $urandom_range(top_page - 100);
            if (seg == 2) hold_asked++;

            for (k = 0; k < SEG_ITEMS; k++) begin
                if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
                    i_in_valid <= 1'b0;
                    repeat ($urandom_range(1, 150)) @(posedge i_clk);
                end
                if ($urandom_range(99) < 20) begin
                    pid  = PID_W'($urandom);
                    addr = $urandom;
                end else begin
                    pid  = $urandom_range(1) ? pid_a : pid_b;
                    addr = ADDR_W'((64'(base_page) + $urandom_range(ws_pages - 1)) * eff_psz
                                   + $urandom_range(eff_psz - 1));
                end
                send_access(pid, addr, 1'b0, '0);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fault_count == 0 && pending_lookups.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
